// File: hw/rtl/afp_pkg.sv
// package: constants and types of the audio frame packetizer
package afp_pkg;

   localparam int unsigned SAMPLE_W       = 32;
   localparam int unsigned STAMP_W        = 32;
   localparam int unsigned FRAME_W        = 14;
   localparam int unsigned LEN_W          = 16;
   localparam int unsigned POS_W          = 4;

   localparam logic [FRAME_W-1:0] FRAME_SAMPLES_RESET = 14'd512;
   localparam logic [FRAME_W-1:0] MAX_FRAME_SAMPLES   = 14'd16383;

   localparam logic [7:0] MAGIC_A = 8'h41;
   localparam logic [7:0] MAGIC_U = 8'h55;
   localparam logic [7:0] MAGIC_D = 8'h44;
   localparam logic [7:0] MAGIC_0 = 8'h30;

   // byte positions within one item's output run
   localparam logic [POS_W-1:0] POS_FIRST_HDR  = 4'd0;
   localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd12;
   localparam logic [POS_W-1:0] POS_LAST       = 4'd15;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [STAMP_W-1:0]  stamp;
      logic [LEN_W-1:0]    len;
      logic                hdr;
      logic                closes;
   } item_type;

endpackage

// File: hw/rtl/audio_frame_packetizer.sv
// audio frame packetizer: samples in, framed little-endian byte stream out
//
// Each accepted sample gives four output bytes, one per cycle while the
// receiver takes them; a sample that opens a frame is preceded by the
// 12-byte header (magic A U D 0, time stamp, payload length, 16-bit byte-sum
// checksum), sixteen bytes in all. The output register sends at most one
// byte per cycle. One sample waits in the input register while the previous
// one is being serialised; the request side is held off while that register
// is full, so a stalled result side stops the input after one sample has
// queued up.
// frame_samples of zero acts as one; a change takes effect at the next sample.
module audio_frame_packetizer
   import afp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] sample_word, [63:32] time_us
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] frame_first, [1] frame_last
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data     // frame_samples
);

   logic [FRAME_W-1:0] frame_samples_ff;
   logic [FRAME_W-1:0] sample_index_ff, sample_index_in;
   logic               p_valid_ff, p_valid_in;
   item_type           p_item_ff, p_item_in;
   logic               w_valid_ff, w_valid_in;
   item_type           w_item_ff, w_item_in;
   logic [LEN_W-1:0]   w_sum_ff, w_sum_in;
   logic [POS_W-1:0]   w_pos_ff, w_pos_in;
   logic               o_valid_ff, o_valid_in;
   logic [7:0]         o_byte_ff, o_byte_in;
   logic               o_first_ff, o_first_in;
   logic               o_flast_ff, o_flast_in;
   logic               o_rlast_ff, o_rlast_in;

   logic [FRAME_W-1:0] eff_frame;
   logic [FRAME_W:0]   index_plus;
   logic               req_xfer;
   logic               advance;
   logic               w_free;
   logic [7:0]         cur_byte;
   logic [LEN_W-1:0]   p_sum;

   assign csr_ready  = 1'b1;
   assign req_tready = !p_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;

   assign eff_frame  = (frame_samples_ff == '0) ? FRAME_W'(1) : frame_samples_ff;
   assign index_plus = {1'b0, sample_index_ff} + (FRAME_W+1)'(1);

   // header byte sum of the waiting item
   assign p_sum = LEN_W'(MAGIC_A) + LEN_W'(MAGIC_U) + LEN_W'(MAGIC_D) + LEN_W'(MAGIC_0)
                + LEN_W'(p_item_ff.stamp[7:0])   + LEN_W'(p_item_ff.stamp[15:8])
                + LEN_W'(p_item_ff.stamp[23:16]) + LEN_W'(p_item_ff.stamp[31:24])
                + LEN_W'(p_item_ff.len[7:0])     + LEN_W'(p_item_ff.len[15:8]);

   assign advance = w_valid_ff && (!o_valid_ff || rsp_tready);
   assign w_free  = !w_valid_ff || (advance && (w_pos_ff == POS_LAST));

   always_comb begin
      case (w_pos_ff)
         4'd0:    cur_byte = MAGIC_A;
         4'd1:    cur_byte = MAGIC_U;
         4'd2:    cur_byte = MAGIC_D;
         4'd3:    cur_byte = MAGIC_0;
         4'd4:    cur_byte = w_item_ff.stamp[7:0];
         4'd5:    cur_byte = w_item_ff.stamp[15:8];
         4'd6:    cur_byte = w_item_ff.stamp[23:16];
         4'd7:    cur_byte = w_item_ff.stamp[31:24];
         4'd8:    cur_byte = w_item_ff.len[7:0];
         4'd9:    cur_byte = w_item_ff.len[15:8];
         4'd10:   cur_byte = w_sum_ff[7:0];
         4'd11:   cur_byte = w_sum_ff[15:8];
         4'd12:   cur_byte = w_item_ff.sample[7:0];
         4'd13:   cur_byte = w_item_ff.sample[15:8];
         4'd14:   cur_byte = w_item_ff.sample[23:16];
         default: cur_byte = w_item_ff.sample[31:24];
      endcase
   end

   always_comb begin
      sample_index_in = sample_index_ff;
      p_valid_in      = p_valid_ff;
      p_item_in       = p_item_ff;
      w_valid_in      = w_valid_ff;
      w_item_in       = w_item_ff;
      w_sum_in        = w_sum_ff;
      w_pos_in        = w_pos_ff;
      o_valid_in      = o_valid_ff;
      o_byte_in       = o_byte_ff;
      o_first_in      = o_first_ff;
      o_flast_in      = o_flast_ff;
      o_rlast_in      = o_rlast_ff;

      if (o_valid_ff && rsp_tready) begin
         o_valid_in = 1'b0;
      end
      if (advance) begin
         o_valid_in = 1'b1;
         o_byte_in  = cur_byte;
         o_first_in = (w_pos_ff == POS_FIRST_HDR);
         o_flast_in = (w_pos_ff == POS_LAST) && w_item_ff.closes;
         o_rlast_in = (w_pos_ff == POS_LAST);
         w_pos_in   = w_pos_ff + POS_W'(1);
      end

      // serialiser takes the waiting item once the previous run is done
      if (w_free) begin
         w_valid_in = p_valid_ff;
         if (p_valid_ff) begin
            p_valid_in = 1'b0;
            w_item_in  = p_item_ff;
            w_sum_in   = p_sum;
            w_pos_in   = p_item_ff.hdr ? POS_FIRST_HDR : POS_FIRST_DATA;
         end
      end

      if (req_xfer) begin
         p_valid_in       = 1'b1;
         p_item_in.sample = req_tdata[31:0];
         p_item_in.stamp  = req_tdata[63:32];
         p_item_in.len    = {eff_frame, 2'b00};
         p_item_in.hdr    = (sample_index_ff == '0);
         p_item_in.closes = (index_plus >= {1'b0, eff_frame});
         sample_index_in  = p_item_in.closes ? '0 : index_plus[FRAME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_samples_ff <= FRAME_SAMPLES_RESET;
         sample_index_ff  <= '0;
         p_valid_ff       <= 1'b0;
         w_valid_ff       <= 1'b0;
         w_pos_ff         <= '0;
         o_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            frame_samples_ff <= csr_data;
         end
         sample_index_ff <= sample_index_in;
         p_valid_ff      <= p_valid_in;
         w_valid_ff      <= w_valid_in;
         w_pos_ff        <= w_pos_in;
         o_valid_ff      <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_item_ff  <= p_item_in;
      w_item_ff  <= w_item_in;
      w_sum_ff   <= w_sum_in;
      o_byte_ff  <= o_byte_in;
      o_first_ff <= o_first_in;
      o_flast_ff <= o_flast_in;
      o_rlast_ff <= o_rlast_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_byte_ff;
   assign rsp_tuser  = {o_flast_ff, o_first_ff};
   assign rsp_tlast  = o_rlast_ff;

`ifndef ASSERT_OFF
   a_first_is_magic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == MAGIC_A && !rsp_tlast)
      else $error("frame start byte is not the magic A");

   a_frame_end_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("frame end not on last byte of a run");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= MAX_FRAME_SAMPLES)
      else $error("sample index beyond frame limit");

   a_header_start: assert property (@(posedge clock) disable iff (reset)
      w_free && p_valid_ff && p_item_ff.hdr |=> w_pos_ff == POS_FIRST_HDR)
      else $error("header item did not start at the first header byte");
`endif

endmodule

// File: tb/audio_frame_packetizer_test.sv
// testbench for the audio frame packetizer: directed table, random samples, byte-level check
module audio_frame_packetizer_test
   import afp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       frame_start;
      logic       frame_end;
      logic       run_end;
   } stream_byte_type;

   typedef struct packed {
      bit                 wr;
      logic [FRAME_W-1:0] frame;
      logic [31:0]        sample;
      logic [31:0]        stamp;
      bit                 typed;
      logic [15:0]        sum;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 14;
   localparam int RANDOM_ITEMS  = 456;
   localparam int QUIET_ITEMS   = 60;
   localparam int HOLD_CYCLES   = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] sample_word, [63:32] time_us
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic [1:0]  rsp_tuser;   // [0] frame_first, [1] frame_last
   logic        rsp_tlast;   // run_last
   logic        csr_valid;
   logic        csr_ready;
   logic [13:0] csr_data;    // frame_samples

   audio_frame_packetizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   stream_byte_type    pending_bytes [$];
   logic [FRAME_W-1:0] frame_size_reg;
   logic [FRAME_W-1:0] samples_in_frame;
   int                 errors;
   bit                 quiet;
   bit                 hold_off_req;
   stim_row_type       directed_rows [DIRECTED_ROWS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** audio_frame_packetizer: FAILED **");
      $finish;
   end

   // byte stream expected for one sample; a typed checksum replaces the computed one
   function automatic void predict_frame_bytes(input logic [31:0] sample,
                                               input logic [31:0] stamp,
                                               input bit sum_typed,
                                               input logic [15:0] sum_given);
      logic [FRAME_W-1:0] n;
      logic [15:0]        len;
      logic [15:0]        sum;
      logic [7:0]         hdr [12];
      bit                 closes;
      n = (frame_size_reg == '0) ? 14'd1 : frame_size_reg;
      if (n > MAX_FRAME_SAMPLES) n = MAX_FRAME_SAMPLES;
      if (samples_in_frame == '0) begin
         len = {n, 2'b00};
         hdr[0] = MAGIC_A;
         hdr[1] = MAGIC_U;
         hdr[2] = MAGIC_D;
         hdr[3] = MAGIC_0;
         for (int i = 0; i < 4; i++) hdr[4 + i] = stamp[8*i +: 8];
         hdr[8] = len[7:0];
         hdr[9] = len[15:8];
         sum = '0;
         for (int i = 0; i < 10; i++) sum = sum + {8'h00, hdr[i]};
         if (sum_typed) sum = sum_given;
         hdr[10] = sum[7:0];
         hdr[11] = sum[15:8];
         for (int i = 0; i < 12; i++) pending_bytes.push_back('{hdr[i], i == 0, 1'b0, 1'b0});
      end
      closes = (int'(samples_in_frame) + 1 >= int'(n));
      for (int i = 0; i < 4; i++)
         pending_bytes.push_back('{sample[8*i +: 8], 1'b0, (i == 3) && closes, i == 3});
      samples_in_frame = closes ? '0 : samples_in_frame + 1'b1;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic push_sample(input logic [31:0] sample, input logic [31:0] stamp,
                              input bit sum_typed, input logic [15:0] sum_given);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, sample};
      do @(posedge clock); while (!req_tready);
      predict_frame_bytes(sample, stamp, sum_typed, sum_given);
      @(negedge clock);
   endtask

   // the block is idle before the register changes
   task automatic set_frame_size(input logic [FRAME_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      frame_size_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      int              idle_left;
      stream_byte_type got;
      stream_byte_type want;
      idle_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            idle_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            idle_left = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast};
            if (pending_bytes.size() == 0) begin
               errors++;
               $display({"%0t: unexpected byte: expected none, ",
                         "actual data %h first %b last %b run_last %b"},
                        $realtime, got.data, got.frame_start, got.frame_end, got.run_end);
            end else begin
               want = pending_bytes.pop_front();
               if (got !== want) begin
                  errors++;
                  $display({"%0t: expected data %h first %b last %b run_last %b, ",
                            "actual data %h first %b last %b run_last %b"},
                           $realtime, want.data, want.frame_start, want.frame_end, want.run_end,
                           got.data, got.frame_start, got.frame_end, got.run_end);
               end
            end
         end
      end
   end

   initial begin
      int                 random_left;
      int                 phase;
      int                 count;
      logic [FRAME_W-1:0] fs;
      logic [31:0]        sample;
      logic [31:0]        stamp;
      errors = 0;
      quiet = 1'b0;
      hold_off_req = 1'b0;
      frame_size_reg = FRAME_SAMPLES_RESET;
      samples_in_frame = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;

      //                   wr    frame     sample          stamp          typed  sum
      directed_rows[0]  = '{1'b0, 14'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0112};
      // shrinking below the samples already sent closes the frame at once
      directed_rows[1]  = '{1'b1, 14'd1,     32'hFFFF_FFFF, 32'h1111_1111, 1'b0, 16'h0000};
      directed_rows[2]  = '{1'b0, 14'd0,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 16'h050A};
      // size zero behaves as one
      directed_rows[3]  = '{1'b1, 14'd0,     32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'h010E};
      directed_rows[4]  = '{1'b1, 14'd16383, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 16'h0701};
      directed_rows[5]  = '{1'b0, 14'd0,     32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0, 16'h0000};
      directed_rows[6]  = '{1'b1, 14'd2,     32'hA5A5_5A5A, 32'h0000_0000, 1'b0, 16'h0000};
      directed_rows[7]  = '{1'b1, 14'd4,     32'h0000_00FF, 32'h0000_0000, 1'b1, 16'h011A};
      directed_rows[8]  = '{1'b0, 14'd0,     32'hFF00_0000, 32'h0102_0304, 1'b0, 16'h0000};
      directed_rows[9]  = '{1'b0, 14'd0,     32'h00FF_FF00, 32'hF0E0_D0C0, 1'b0, 16'h0000};
      directed_rows[10] = '{1'b0, 14'd0,     32'h5555_AAAA, 32'h7777_8888, 1'b0, 16'h0000};
      directed_rows[11] = '{1'b1, 14'd3,     32'h0F0F_F0F0, 32'h89AB_CDEF, 1'b0, 16'h0000};
      // growing mid-frame keeps the frame open
      directed_rows[12] = '{1'b1, 14'd6,     32'h3C3C_C3C3, 32'h0000_FFFF, 1'b0, 16'h0000};
      directed_rows[13] = '{1'b0, 14'd0,     32'h0000_0001, 32'hFFFF_0000, 1'b0, 16'h0000};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].wr) set_frame_size(directed_rows[r].frame);
         push_sample(directed_rows[r].sample, directed_rows[r].stamp,
                     directed_rows[r].typed, directed_rows[r].sum);
      end

      random_left = RANDOM_ITEMS;
      phase = 0;
      while (random_left > 0) begin
         case ($urandom_range(0, 9))
            0: begin fs = '0; count = $urandom_range(5, 15); end
            1: begin fs = MAX_FRAME_SAMPLES; count = $urandom_range(5, 12); end
            2: begin fs = 14'd1; count = $urandom_range(10, 30); end
            3: begin fs = FRAME_SAMPLES_RESET; count = $urandom_range(5, 12); end
            default: begin fs = 14'($urandom_range(1, 8)); count = $urandom_range(15, 40); end
         endcase
         if (count > random_left) count = random_left;
         set_frame_size(fs);
         // long receiver stall while samples keep coming, so the input backs up
         if (phase == 2) hold_off_req = 1'b1;
         for (int k = 0; k < count; k++) begin
            if (random_left <= QUIET_ITEMS) quiet = 1'b1;
            case ($urandom_range(0, 7))
               0: sample = 32'h8000_0000;
               1: sample = 32'h7FFF_FFFF;
               2: sample = '0;
               3: sample = '1;
               default: sample = $urandom;
            endcase
            case ($urandom_range(0, 7))
               0: stamp = '0;
               1: stamp = '1;
               default: stamp = $urandom;
            endcase
            push_sample(sample, stamp, 1'b0, 16'h0000);
            random_left--;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("** audio_frame_packetizer: PASSED **");
      end else begin
         $display("** audio_frame_packetizer: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/afp_pkg.sv
hw/rtl/audio_frame_packetizer.sv
tb/audio_frame_packetizer_test.sv
